[rtl/assert_macros.svh]
// Assertion macros for the top module, which checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

[rtl/imp_pkg.sv]
`default_nettype none

package imp_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_SIZE_DEF = 8;
    localparam int SIZE_W       = 4;
    localparam int EXP_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATRIX_SIZE = 2'd0,
        REG_EXPONENT    = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        MOVE_NONE   = 2'd0,
        MOVE_INIT   = 2'd1,
        MOVE_COPY_P = 2'd2,
        MOVE_COPY_S = 2'd3
    } move_op_t;

    typedef enum logic {
        MAC_PS = 1'b0,
        MAC_SS = 1'b1
    } mac_mode_t;

    typedef struct packed {
        logic      in_write;
        move_op_t  move_op;
        logic      move_diag;
        logic      mac_valid;
        logic      mac_first;
        logic      mac_last;
        mac_mode_t mac_mode;
        logic      out_load;
        logic      out_last;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/integer_matrix_power.sv]
// Loading takes n*n words, one per cycle while in_ready is high; the last word
// starts the computation. With k > 0 the power needs popcount(k) + floor(log2(k))
// products, each on the single multiply-accumulate unit and followed by a copy.
// Setup initialises the working matrices; results leave one word at a time through
// the registered read of the product memory, each only when the output is not stalled.
// Reset clears control state and sets matrix_size and exponent to 1; memories hold no reset.
`default_nettype none
`include "assert_macros.svh"

module integer_matrix_power #(
    parameter int MAX_SIZE = imp_pkg::MAX_SIZE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [imp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [imp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [imp_pkg::DATA_W-1:0] element,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [imp_pkg::DATA_W-1:0]      value,
    output logic                                   last
);

    localparam int CELLS = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    imp_pkg::cmd_t cmd;
    logic          out_busy;
    logic [AW-1:0] load_addr;
    logic [AW-1:0] move_addr;
    logic [AW-1:0] p_rd_addr;
    logic [AW-1:0] s_rd_a_addr;
    logic [AW-1:0] s_rd_b_addr;
    logic [AW-1:0] mac_wr_addr;

    imp_ctrl #(
        .MAX_SIZE(MAX_SIZE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_busy   (out_busy),
        .cmd        (cmd),
        .load_addr  (load_addr),
        .move_addr  (move_addr),
        .p_rd_addr  (p_rd_addr),
        .s_rd_a_addr(s_rd_a_addr),
        .s_rd_b_addr(s_rd_b_addr),
        .mac_wr_addr(mac_wr_addr)
    );

    imp_datapath #(
        .MAX_SIZE(MAX_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_addr  (load_addr),
        .move_addr  (move_addr),
        .p_rd_addr  (p_rd_addr),
        .s_rd_a_addr(s_rd_a_addr),
        .s_rd_b_addr(s_rd_b_addr),
        .mac_wr_addr(mac_wr_addr),
        .element    (element),
        .value      (value),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_busy   (out_busy)
    );

    `IMP_ASSERT_IMPL(a_mac_excludes_move, clk, rst_n, cmd.mac_valid, cmd.move_op == imp_pkg::MOVE_NONE)
    `IMP_ASSERT_IMPL(a_load_quiet, clk, rst_n, in_valid && in_ready, !cmd.mac_valid && !cmd.out_load && cmd.move_op == imp_pkg::MOVE_NONE)
    `IMP_ASSERT_IMPL(a_out_from_load, clk, rst_n, $rose(out_valid), $past(cmd.out_load))
    `IMP_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid)

endmodule

`default_nettype wire

[rtl/imp_datapath.sv]
`default_nettype none

module imp_datapath #(
    parameter  int MAX_SIZE = imp_pkg::MAX_SIZE_DEF,
    localparam int CELLS    = MAX_SIZE * MAX_SIZE,
    localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire imp_pkg::cmd_t                      cmd,
    input  wire logic [AW-1:0]                      load_addr,
    input  wire logic [AW-1:0]                      move_addr,
    input  wire logic [AW-1:0]                      p_rd_addr,
    input  wire logic [AW-1:0]                      s_rd_a_addr,
    input  wire logic [AW-1:0]                      s_rd_b_addr,
    input  wire logic [AW-1:0]                      mac_wr_addr,
    input  wire logic signed [imp_pkg::DATA_W-1:0]  element,
    output logic signed [imp_pkg::DATA_W-1:0]       value,
    output logic                                    last,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    out_busy
);

    localparam int DW    = imp_pkg::DATA_W;

    logic [DW-1:0] src_mem [CELLS];
    logic [DW-1:0] p_mem   [CELLS];
    logic [DW-1:0] s_mem   [CELLS];
    logic [DW-1:0] t_mem   [CELLS];

    logic [DW-1:0] src_rd_reg;
    logic [DW-1:0] t_rd_reg;
    logic [DW-1:0] p_rd_reg;
    logic [DW-1:0] sa_rd_reg;
    logic [DW-1:0] sb_rd_reg;

    imp_pkg::move_op_t  mv_op1_reg;
    logic [AW-1:0]      mv_addr1_reg;
    logic               mv_diag1_reg;

    logic               s1_valid_reg;
    logic               s1_first_reg;
    logic               s1_last_reg;
    imp_pkg::mac_mode_t s1_mode_reg;
    logic [AW-1:0]      s1_addr_reg;

    logic               s2_valid_reg;
    logic               s2_first_reg;
    logic               s2_last_reg;
    logic [AW-1:0]      s2_addr_reg;

    logic [DW-1:0]      mul_reg;
    logic [DW-1:0]      acc_reg;
    logic [DW-1:0]      acc_next;
    logic [DW-1:0]      op_a;
    logic [2*DW-1:0]    mul_full;

    logic               p_we;
    logic               s_we;
    logic [DW-1:0]      p_wd;
    logic [DW-1:0]      s_wd;

    logic [DW-1:0]      value_reg;
    logic               last_reg;
    logic               out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.in_write)
        begin
            src_mem[load_addr] <= element;
        end
        src_rd_reg <= src_mem[move_addr];
        t_rd_reg   <= t_mem[move_addr];
        p_rd_reg   <= p_mem[p_rd_addr];
        sa_rd_reg  <= s_mem[s_rd_a_addr];
        sb_rd_reg  <= s_mem[s_rd_b_addr];
    end

    always_comb
    begin
        p_we = 1'b0;
        s_we = 1'b0;
        p_wd = t_rd_reg;
        s_wd = t_rd_reg;
        case (mv_op1_reg)
            imp_pkg::MOVE_INIT:
            begin
                p_we = 1'b1;
                p_wd = mv_diag1_reg ? DW'(1) : '0;
                s_we = 1'b1;
                s_wd = src_rd_reg;
            end
            imp_pkg::MOVE_COPY_P:
            begin
                p_we = 1'b1;
            end
            imp_pkg::MOVE_COPY_S:
            begin
                s_we = 1'b1;
            end
            default:
            begin
                p_we = 1'b0;
                s_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_mem[mv_addr1_reg] <= p_wd;
        end
        if (s_we)
        begin
            s_mem[mv_addr1_reg] <= s_wd;
        end
    end

    assign op_a     = (s1_mode_reg == imp_pkg::MAC_PS) ? p_rd_reg : sa_rd_reg;
    assign mul_full = op_a * sb_rd_reg;
    assign acc_next = s2_first_reg ? mul_reg : acc_reg + mul_reg;

    always_ff @(posedge clk)
    begin
        mv_addr1_reg <= move_addr;
        mv_diag1_reg <= cmd.move_diag;
        s1_first_reg <= cmd.mac_first;
        s1_last_reg  <= cmd.mac_last;
        s1_mode_reg  <= cmd.mac_mode;
        s1_addr_reg  <= mac_wr_addr;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_addr_reg  <= s1_addr_reg;
        mul_reg      <= mul_full[DW-1:0];
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
            if (s2_last_reg)
            begin
                t_mem[s2_addr_reg] <= acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_op1_reg   <= imp_pkg::MOVE_NONE;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            mv_op1_reg   <= cmd.move_op;
            s1_valid_reg <= cmd.mac_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            value_reg <= p_rd_reg;
            last_reg  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign value     = value_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;
    assign out_busy  = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

[rtl/imp_ctrl.sv]
`default_nettype none

module imp_ctrl #(
    parameter  int MAX_SIZE = imp_pkg::MAX_SIZE_DEF,
    localparam int CELLS    = MAX_SIZE * MAX_SIZE,
    localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [imp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [imp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              out_busy,
    output imp_pkg::cmd_t                          cmd,
    output logic [AW-1:0]                          load_addr,
    output logic [AW-1:0]                          move_addr,
    output logic [AW-1:0]                          p_rd_addr,
    output logic [AW-1:0]                          s_rd_a_addr,
    output logic [AW-1:0]                          s_rd_b_addr,
    output logic [AW-1:0]                          mac_wr_addr
);

    localparam int LW    = $clog2(CELLS + 1);
    localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW    = $clog2(MAX_SIZE + 1);
    localparam int MSW   = imp_pkg::SIZE_W;
    localparam int EW    = imp_pkg::EXP_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_CHECK,
        ST_MUL,
        ST_DRAIN,
        ST_COPY,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

    state_t             state_reg, state_next;
    logic [LW-1:0]      load_count_reg, load_count_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [IW-1:0]      t_reg, t_next;
    logic [SW-1:0]      n_reg, n_next;
    logic [EW-1:0]      power_reg, power_next;
    imp_pkg::mac_mode_t mode_reg, mode_next;
    logic               drain_reg, drain_next;
    logic [MSW-1:0]     matrix_size_reg, matrix_size_next;
    logic [EW-1:0]      exponent_reg, exponent_next;

    logic [SW-1:0]      n_cur;
    logic [LW-1:0]      cells_cur;
    logic [IW-1:0]      last_idx;
    logic               i_end;
    logic               j_end;
    logic               t_end;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                                input logic [IW-1:0] c,
                                                input logic [SW-1:0] n);
        cell_addr = AW'(r) * AW'(n) + AW'(c);
    endfunction

    always_comb
    begin
        if (matrix_size_reg == '0)
        begin
            n_cur = SW'(1);
        end
        else if (32'(matrix_size_reg) > MAX_SIZE)
        begin
            n_cur = SW'(MAX_SIZE);
        end
        else
        begin
            n_cur = SW'(matrix_size_reg);
        end
    end

    assign cells_cur = LW'(n_cur) * LW'(n_cur);
    assign last_idx  = IW'(n_reg - SW'(1));
    assign i_end     = (i_reg == last_idx);
    assign j_end     = (j_reg == last_idx);
    assign t_end     = (t_reg == last_idx);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        matrix_size_next = matrix_size_reg;
        exponent_next    = exponent_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                imp_pkg::REG_MATRIX_SIZE: matrix_size_next = cfg_data[MSW-1:0];
                imp_pkg::REG_EXPONENT:    exponent_next    = cfg_data[EW-1:0];
                default:
                begin
                    matrix_size_next = matrix_size_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        t_next          = t_reg;
        n_next          = n_reg;
        power_next      = power_reg;
        mode_next       = mode_reg;
        drain_next      = drain_reg;

        in_ready        = 1'b0;
        cmd             = '0;
        cmd.move_op     = imp_pkg::MOVE_NONE;
        cmd.mac_mode    = mode_reg;
        load_addr       = load_count_reg[AW-1:0];
        move_addr       = cell_addr(i_reg, j_reg, n_reg);
        p_rd_addr       = cell_addr(i_reg, t_reg, n_reg);
        s_rd_a_addr     = cell_addr(i_reg, t_reg, n_reg);
        s_rd_b_addr     = cell_addr(t_reg, j_reg, n_reg);
        mac_wr_addr     = cell_addr(i_reg, j_reg, n_reg);

        case (state_reg)
            ST_LOAD:
            begin
                in_ready     = 1'b1;
                cmd.in_write = in_valid;
                if (in_valid)
                begin
                    if (load_count_reg + LW'(1) >= cells_cur)
                    begin
                        load_count_next = '0;
                        n_next          = n_cur;
                        power_next      = exponent_reg;
                        i_next          = '0;
                        j_next          = '0;
                        state_next      = ST_INIT;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + LW'(1);
                    end
                end
            end
            ST_INIT, ST_COPY:
            begin
                if (state_reg == ST_INIT)
                begin
                    cmd.move_op   = imp_pkg::MOVE_INIT;
                    cmd.move_diag = (i_reg == j_reg);
                end
                else if (mode_reg == imp_pkg::MAC_PS)
                begin
                    cmd.move_op = imp_pkg::MOVE_COPY_P;
                end
                else
                begin
                    cmd.move_op = imp_pkg::MOVE_COPY_S;
                end
                if (j_end)
                begin
                    j_next = '0;
                    if (i_end)
                    begin
                        i_next     = '0;
                        state_next = ST_CHECK;
                        if (state_reg == ST_COPY && mode_reg == imp_pkg::MAC_PS)
                        begin
                            power_next = {power_reg[EW-1:1], 1'b0};
                        end
                    end
                    else
                    begin
                        i_next = i_reg + IW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_CHECK:
            begin
                i_next = '0;
                j_next = '0;
                t_next = '0;
                if (power_reg == '0)
                begin
                    state_next = ST_OUT_RD;
                end
                else if (power_reg[0])
                begin
                    mode_next  = imp_pkg::MAC_PS;
                    state_next = ST_MUL;
                end
                else
                begin
                    power_next = power_reg >> 1;
                    if ((power_reg >> 1) != '0)
                    begin
                        mode_next  = imp_pkg::MAC_SS;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mac_valid = 1'b1;
                cmd.mac_first = (t_reg == '0);
                cmd.mac_last  = t_end;
                if (t_end)
                begin
                    t_next = '0;
                    if (j_end)
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            i_next     = '0;
                            drain_next = 1'b0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                end
                else
                begin
                    t_next = t_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_OUT_RD:
            begin
                p_rd_addr = cell_addr(i_reg, j_reg, n_reg);
                if (!out_busy)
                begin
                    state_next = ST_OUT_WR;
                end
            end
            ST_OUT_WR:
            begin
                cmd.out_load = 1'b1;
                cmd.out_last = i_end && j_end;
                if (j_end)
                begin
                    j_next = '0;
                    if (i_end)
                    begin
                        i_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            load_count_reg  <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            t_reg           <= '0;
            n_reg           <= SW'(1);
            power_reg       <= '0;
            mode_reg        <= imp_pkg::MAC_PS;
            drain_reg       <= 1'b0;
            matrix_size_reg <= MSW'(1);
            exponent_reg    <= EW'(1);
        end
        else
        begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            t_reg           <= t_next;
            n_reg           <= n_next;
            power_reg       <= power_next;
            mode_reg        <= mode_next;
            drain_reg       <= drain_next;
            matrix_size_reg <= matrix_size_next;
            exponent_reg    <= exponent_next;
        end
    end

endmodule

`default_nettype wire

[tb/sv/integer_matrix_power_tb.sv]
module integer_matrix_power_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_B = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 435;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } result_word_t;

    class power_scoreboard;
        bit [SIZE_W-1:0] size_reg = 4'd1;
        bit [EXP_W-1:0] exponent_reg = 16'd1;
        bit [DATA_W-1:0] source [64];
        bit [DATA_W-1:0] product [64];
        bit [DATA_W-1:0] square [64];
        int load_count = 0;
        int errors = 0;
        result_word_t expected_words [$];

        function void note_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_MATRIX_SIZE)
                size_reg = data[SIZE_W-1:0];
            else if (index == REG_EXPONENT)
                exponent_reg = data;
        endfunction

        // Either product = product * square or square = square * square, modulo 2^32.
        function void multiply(int n, bit square_only);
            bit [DATA_W-1:0] tmp [64];
            bit [DATA_W-1:0] acc;
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    acc = '0;
                    for (int t = 0; t < n; t++)
                        acc += (square_only ? square[i*n+t] : product[i*n+t]) * square[t*n+j];
                    tmp[i*n+j] = acc;
                end
            end
            for (int i = 0; i < n * n; i++)
            begin
                if (square_only)
                    square[i] = tmp[i];
                else
                    product[i] = tmp[i];
            end
        endfunction

        function void raise_to_power(int n);
            bit [EXP_W-1:0] bits;
            for (int i = 0; i < n * n; i++)
            begin
                product[i] = (i / n == i % n) ? 32'd1 : 32'd0;
                square[i] = source[i];
            end
            bits = exponent_reg;
            while (bits != 0)
            begin
                if (bits[0])
                    multiply(n, 1'b0);
                bits = bits >> 1;
                if (bits != 0)
                    multiply(n, 1'b1);
            end
        endfunction

        function void note_element(logic signed [DATA_W-1:0] data);
            int n;
            result_word_t w;
            n = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(size_reg);
            source[load_count % 64] = data;
            load_count = (load_count + 1) % 128;
            if (load_count < n * n)
                return;
            load_count = 0;
            raise_to_power(n);
            for (int i = 0; i < n * n; i++)
            begin
                w.value = product[i];
                w.last = (i == n * n - 1);
                expected_words.push_back(w);
            end
        endfunction

        function void check_word(logic signed [DATA_W-1:0] got_value, logic got_last);
            result_word_t w;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, value %0d last %0b", $time, got_value, got_last);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (got_value !== w.value)
            begin
                $display("%0t: value mismatch, expected %0d, got %0d", $time, w.value, got_value);
                errors++;
            end
            if (got_last !== w.last)
            begin
                $display("%0t: last mismatch, expected %0b, got %0b", $time, w.last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [DATA_W-1:0] element;
    logic out_valid;
    logic out_ready;
    logic signed [DATA_W-1:0] value;
    logic last;

    int idle_pct;
    int stall_pct;
    bit hold_request;
    int hold_left;
    power_scoreboard sb;

    integer_matrix_power dut (.*);

    always #5ns clk = ~clk;

    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(value, last);
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_element(input logic signed [DATA_W-1:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        element <= data;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        sb.note_element(data);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sb.note_register(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drops the input word and waits until every predicted result has left the block.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] random_element();
        int v;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                v = $urandom_range(0, 6);
                return v - 3;
            end
            2:
            begin
                v = $urandom_range(0, 2);
                return (v == 0) ? 32'h7FFF_FFFF : (v == 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
            end
            default:
            begin
                v = $urandom_range(0, 65535);
                return v - 32768;
            end
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase;
        int raw;
        int expo;
        int mats;
        int items;
        int n;
        logic [CFG_DATA_W-1:0] data16;

        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        element = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MATRIX_SIZE;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_element(32'h8000_0000);

        wait_idle();
        write_reg(REG_MATRIX_SIZE, 16'hFFF2);
        write_reg(REG_EXPONENT, 16'h0000);
        send_element(32'h7FFF_FFFF);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_0000);
        send_element(32'h0000_0001);

        wait_idle();
        write_reg(REG_RESERVED_A, 16'h0003);
        write_reg(REG_RESERVED_B, 16'hFFFF);
        write_reg(REG_EXPONENT, 16'hFFFF);
        send_element(32'h0000_0001);
        send_element(32'h0000_0001);
        send_element(32'h0000_0001);
        send_element(32'h0000_0000);

        wait_idle();
        write_reg(REG_MATRIX_SIZE, 16'h0000);
        write_reg(REG_EXPONENT, 16'h0002);
        send_element(32'h8000_0001);

        wait_idle();
        write_reg(REG_MATRIX_SIZE, 16'h0003);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_0000);
        send_element(32'h0000_0001);
        send_element(32'hFFFF_FFFE);
        send_element(32'h0000_3039);
        send_element(32'hFFFF_FFF9);
        send_element(32'h0000_0003);

        // A size cut in the middle of a load makes the next word complete the matrix.
        wait_idle();
        write_reg(REG_EXPONENT, 16'h0001);
        repeat (5) send_element(random_element());
        wait_idle();
        write_reg(REG_MATRIX_SIZE, 16'h0002);
        send_element(random_element());

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            case (phase % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    idle_pct = 16;
                    stall_pct = 16;
                end
            endcase
            if (phase == 0)
            begin
                raw = 12;
                expo = $urandom_range(0, 3);
                mats = 1;
            end
            else if (phase == 1)
            begin
                raw = 8;
                expo = 65535;
                mats = 1;
            end
            else if (phase == 4)
            begin
                raw = 2;
                expo = 3;
                mats = 4;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: raw = $urandom_range(9, 15);
                    1: raw = 0;
                    2, 3: raw = $urandom_range(5, 8);
                    default: raw = $urandom_range(1, 4);
                endcase
                expo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 12);
                mats = (raw > 4) ? 1 : $urandom_range(1, 4);
            end
            data16 = 16'($urandom);
            data16[SIZE_W-1:0] = 4'(raw);
            write_reg(REG_MATRIX_SIZE, data16);
            write_reg(REG_EXPONENT, 16'(expo));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_RESERVED_A : REG_RESERVED_B, 16'($urandom));
            if (phase == 4)
                hold_request = 1'b1;
            n = (raw == 0) ? 1 : (raw > MAX_SIZE_DEF) ? MAX_SIZE_DEF : raw;
            items = mats * n * n;
            if (phase > 4 && $urandom_range(0, 3) == 0)
                items += $urandom_range(1, n * n);
            repeat (items) send_element(random_element());
            sent += items;
            phase++;
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
